FILE: rtl/fwhrf_pkg.sv
// Package for the finger/wrist heart-rate fusion block: beat layouts, command
// codes, rate thresholds and the waveform quality score.
// Depends on nothing; used by rtl/finger_wrist_heart_rate_fusion.sv.
package fwhrf_pkg;

	// Command codes carried in the input tuser.
	typedef enum logic [1:0] {
		CMD_FINGER = 2'd0,
		CMD_WRIST  = 2'd1,
		CMD_RESET  = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_WARMUP_ID_LOW   = 2'd0;
	localparam logic [1:0] REG_WARMUP_ID_HIGH  = 2'd1;
	localparam logic [1:0] REG_WARMUP_RATE_MIN = 2'd2;
	localparam logic [1:0] REG_WARMUP_RATE_MAX = 2'd3;

	// Register reset values.
	localparam logic [15:0] WARMUP_ID_LOW_RST   = 16'd0;
	localparam logic [15:0] WARMUP_ID_HIGH_RST  = 16'd2;
	localparam logic [7:0]  WARMUP_RATE_MIN_RST = 8'd40;
	localparam logic [7:0]  WARMUP_RATE_MAX_RST = 8'd150;

	// Rate thresholds in beats per minute.
	localparam logic [7:0] OX_LO      = 8'd64;
	localparam logic [7:0] OX_HI      = 8'd72;
	localparam logic [7:0] ACT_LO     = 8'd76;
	localparam logic [7:0] ACT_HI     = 8'd98;
	localparam logic [7:0] FINGER_MIN = 8'd58;
	localparam logic [7:0] GAP_MAX    = 8'd5;
	localparam logic [7:0] CALM_CAP   = 8'd75;
	localparam logic [7:0] WARM_DEF   = 8'd70;

	// Quality weights in hundredths.
	localparam logic [6:0] Q_PROM   = 7'd35;
	localparam logic [6:0] Q_SPREAD = 7'd25;
	localparam logic [6:0] Q_ENERGY = 7'd20;
	localparam logic [6:0] Q_FREQ   = 7'd20;
	localparam logic [6:0] Q_FUSION = 7'd15;

	// Reciprocals (scaled by 2^16) for the divides by ten and by five.
	localparam logic [12:0] RECIP_10 = 13'd6554;
	localparam logic [13:0] RECIP_5  = 14'd13108;

	// Input beat, last field in the lowest bits.
	typedef struct packed {
		logic [6:0]         pad;
		logic signed [15:0] dominant_freq;
		logic signed [15:0] peak_energy;
		logic signed [15:0] spread;
		logic signed [15:0] prominence;
		logic               wave_valid;
		logic [7:0]         rate_in;
		logic [15:0]        pulse_number;
	} item_t;

	// Result beat, last field in the lowest bits.
	typedef struct packed {
		logic [6:0] pad;
		logic       wrist_good;
		logic       finger_good;
		logic [6:0] quality;
		logic [7:0] rate_out;
	} result_t;

	// Waveform quality score, 0..100.
	function automatic logic [6:0] wave_score(input item_t it);
		logic [6:0] s;
		s = 7'd0;
		if (it.wave_valid) begin
			if (it.prominence >= 16'sd12) s = s + Q_PROM;
			if (it.spread >= 16'sd4 && it.spread <= 16'sd90) s = s + Q_SPREAD;
			if (it.peak_energy >= 16'sd15) s = s + Q_ENERGY;
			if (it.dominant_freq >= 16'sd8 && it.dominant_freq <= 16'sd35) s = s + Q_FREQ;
		end
		return s;
	endfunction

	function automatic logic active_rate(input logic [7:0] r);
		return (r >= ACT_LO) && (r <= ACT_HI);
	endfunction

endpackage

FILE: rtl/finger_wrist_heart_rate_fusion.sv
// Finger/wrist heart-rate fusion: qualifies finger beats, fuses wrist beats.
// Depends on rtl/fwhrf_pkg.sv.
// Timing: one beat per cycle is sustained while the output side takes results.
// Each beat is captured in an input register and its result is then written to
// the output register; the stored finger beat is updated at the same edge as
// the result register, so every beat sees the state left by the one before it.
// Ready on the input side is low only while both the input register and the
// output register hold beats that the output side has not taken. The
// configuration port always accepts writes and takes effect on the next beat.
module finger_wrist_heart_rate_fusion
	import fwhrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input beats.
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata from bit 0: pulse_number[15:0], rate_in[7:0], wave_valid,
	// prominence[15:0], spread[15:0], peak_energy[15:0], dominant_freq[15:0], zero pad.
	input  logic [95:0] s_tdata,
	// tuser: command[1:0].
	input  logic [1:0]  s_tuser,
	// Result beats.
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata from bit 0: rate_out[7:0], quality[6:0], finger_good, wrist_good, zero pad.
	output logic [23:0] m_tdata,
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	logic [15:0] warm_lo_q, warm_hi_q;
	logic [7:0]  warm_min_q, warm_max_q;

	// Stored finger beat.
	logic [15:0] last_pulse_q;
	logic [7:0]  last_rate_q;
	logic        last_valid_q, last_active_q, session_on_q;

	// Input register.
	logic        valid_s1;
	item_t       item_s1;
	cmd_t        cmd_s1;

	// Output register.
	logic        out_valid_q;
	result_t     res_q;

	// Next values from the combinational pass.
	result_t     res_d;
	logic [15:0] last_pulse_d;
	logic [7:0]  last_rate_d;
	logic        last_valid_d, last_active_d, session_on_d;

	logic        advance;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = res_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_lo_q  <= WARMUP_ID_LOW_RST;
			warm_hi_q  <= WARMUP_ID_HIGH_RST;
			warm_min_q <= WARMUP_RATE_MIN_RST;
			warm_max_q <= WARMUP_RATE_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WARMUP_ID_LOW:   warm_lo_q  <= cfg_data;
				REG_WARMUP_ID_HIGH:  warm_hi_q  <= cfg_data;
				REG_WARMUP_RATE_MIN: warm_min_q <= cfg_data[7:0];
				REG_WARMUP_RATE_MAX: warm_max_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'(s_tdata);
			cmd_s1  <= cmd_t'(s_tuser);
		end
	end

	// Qualification and fusion of the beat in the input register.
	always_comb begin
		logic [7:0]  hr;
		logic        warm, ok, match, wact, done;
		logic [6:0]  q;
		logic [11:0] sum9;
		logic [24:0] prod10;
		logic [7:0]  f;
		logic [10:0] sum5;
		logic [24:0] prod5;
		logic [7:0]  d;
		logic [9:0]  sum3;

		res_d         = '0;
		last_pulse_d  = last_pulse_q;
		last_rate_d   = last_rate_q;
		last_valid_d  = last_valid_q;
		last_active_d = last_active_q;
		session_on_d  = session_on_q;

		hr    = item_s1.rate_in;
		warm  = (item_s1.pulse_number >= warm_lo_q) && (item_s1.pulse_number <= warm_hi_q);
		ok    = 1'b0;
		match = last_valid_q && (last_pulse_q == item_s1.pulse_number);
		wact  = active_rate(hr) || session_on_q;
		done  = 1'b0;
		q     = wave_score(item_s1);
		f     = 8'd0;

		// Finger-weighted blend: (9 * finger + wrist + 5) / 10.
		sum9   = {1'b0, last_rate_q, 3'b000} + {4'b0, last_rate_q} + {4'b0, hr} + 12'd5;
		prod10 = {13'b0, sum9} * {12'b0, RECIP_10};
		// Calm blend: (2 * wrist + 3 * finger + 2) / 5.
		sum5   = {2'b0, hr, 1'b0} + {2'b0, last_rate_q, 1'b0} + {3'b0, last_rate_q} + 11'd2;
		prod5  = {14'b0, sum5} * {11'b0, RECIP_5};
		// Compression above the calm cap: (3 * wrist + 70) / 4.
		sum3   = {1'b0, hr, 1'b0} + {2'b0, hr} + 10'd70;
		d      = (hr > last_rate_q) ? (hr - last_rate_q) : (last_rate_q - hr);

		case (cmd_s1)
			CMD_FINGER: begin
				if (hr == 8'd0) begin
					if (warm) begin
						hr = WARM_DEF;
						ok = 1'b1;
					end
				end else if (warm) begin
					ok = (hr >= warm_min_q) && (hr <= warm_max_q);
				end else if (hr >= FINGER_MIN) begin
					if (hr < OX_LO) hr = OX_LO;
					ok = 1'b1;
				end
				if (ok) begin
					res_d.quality     = q;
					res_d.finger_good = 1'b1;
					res_d.rate_out    = hr;
					last_pulse_d  = item_s1.pulse_number;
					last_rate_d   = hr;
					last_valid_d  = ((hr >= OX_LO) && (hr <= OX_HI)) || active_rate(hr)
						|| session_on_q;
					last_active_d = active_rate(hr) || session_on_q;
					session_on_d  = session_on_q || active_rate(hr);
				end
			end
			CMD_WRIST: begin
				if (hr != 8'd0) begin
					res_d.wrist_good = 1'b1;
					if (wact || last_active_q) begin
						res_d.finger_good = match;
						if (match && (last_active_q || session_on_q)
							&& ({1'b0, last_rate_q} > ({1'b0, hr} + {1'b0, GAP_MAX}))) begin
							f = prod10[23:16];
							if (f < hr) f = hr;
							if (f > ACT_HI) f = ACT_HI;
							q = q + Q_FUSION;
							res_d.rate_out = f;
						end else begin
							res_d.rate_out = (hr > ACT_HI) ? ACT_HI : hr;
						end
						done = 1'b1;
					end else if (match && (last_rate_q >= OX_LO) && (last_rate_q <= OX_HI)) begin
						res_d.finger_good = 1'b1;
						if (d > GAP_MAX) begin
							f = prod5[23:16];
							if (f < OX_LO) f = OX_LO;
							if (f > CALM_CAP) f = CALM_CAP;
							q = q + Q_FUSION;
							res_d.rate_out = f;
							done = 1'b1;
						end
					end
					if (!done) begin
						res_d.rate_out = (hr > CALM_CAP) ? sum3[9:2] : hr;
					end
					res_d.quality = q;
				end
			end
			CMD_RESET: begin
				last_valid_d  = 1'b0;
				last_active_d = 1'b0;
				session_on_d  = 1'b0;
			end
			default: ;
		endcase
	end

	// Output register and finger-beat state, updated together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			last_pulse_q  <= '0;
			last_rate_q   <= '0;
			last_valid_q  <= 1'b0;
			last_active_q <= 1'b0;
			session_on_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				last_pulse_q  <= last_pulse_d;
				last_rate_q   <= last_rate_d;
				last_valid_q  <= last_valid_d;
				last_active_q <= last_active_d;
				session_on_q  <= session_on_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_d;
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for finger_wrist_heart_rate_fusion: a directed table, then random
// finger/wrist pulse sequences, each checked against a typed row or an in-house predictor.
// Depends on rtl/fwhrf_pkg.sv and rtl/finger_wrist_heart_rate_fusion.sv.
module testbench;
	import fwhrf_pkg::*;

	// One row of the directed table; typed rows carry their expected result.
	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] pulse;
		logic [7:0]  rate;
		logic        wave_ok;
		logic [15:0] prom;
		logic [15:0] spread;
		logic [15:0] energy;
		logic [15:0] freq;
		logic        typed;
		logic [7:0]  x_rate;
		logic [6:0]  x_quality;
		logic        x_finger;
		logic        x_wrist;
	} probe_t;

	localparam int PROBES = 21;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_AT = 500;
	localparam int HOLD_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [1:0]  s_tuser = CMD_FINGER;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_WARMUP_ID_LOW;
	logic [15:0] cfg_data = '0;

	// Predictor copy of the configuration and of the stored finger beat.
	logic [15:0] warm_id_lo = WARMUP_ID_LOW_RST;
	logic [15:0] warm_id_hi = WARMUP_ID_HIGH_RST;
	logic [7:0]  warm_rate_lo = WARMUP_RATE_MIN_RST;
	logic [7:0]  warm_rate_hi = WARMUP_RATE_MAX_RST;
	logic [15:0] stored_pulse = '0;
	logic [7:0]  stored_rate = '0;
	logic        stored_valid = 1'b0;
	logic        stored_active = 1'b0;
	logic        session_live = 1'b0;

	result_t pending_results[$];
	int          mismatches = 0;
	int          beats_taken = 0;
	int          burst_left = 0;
	int          hold_left = 0;
	logic [15:0] recent_finger = '0;
	logic [15:0] next_pulse = 16'd100;

	// Directed table: extremes, every command and the special cases.
	probe_t probes [PROBES] = '{
		// zero warm-up rate becomes the default rate
		'{CMD_FINGER, 16'd1, 8'd0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 8'd70, 7'd0, 1'b1, 1'b0},
		// warm-up rate below the window is rejected
		'{CMD_FINGER, 16'd1, 8'd39, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1'b1, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_FINGER, 16'd2, 8'd150, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		// below the finger minimum outside warm-up
		'{CMD_FINGER, 16'd3, 8'd57, 1'b1, 16'd12, 16'd4, 16'd15, 16'd8,
			1'b1, 8'd0, 7'd0, 1'b0, 1'b0},
		// lifted to the low oximeter bound, lowest features score nothing
		'{CMD_FINGER, 16'd4, 8'd58, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			1'b1, 8'd64, 7'd0, 1'b1, 1'b0},
		// wrist beat without a rate gives nothing
		'{CMD_WRIST, 16'd4, 8'd0, 1'b1, 16'd12, 16'd4, 16'd15, 16'd8,
			1'b1, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_WRIST, 16'd4, 8'd80, 1'b1, 16'd12, 16'd4, 16'd15, 16'd8,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_WRIST, 16'd4, 8'd72, 1'b1, 16'd11, 16'd3, 16'd14, 16'd7,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_WRIST, 16'd4, 8'd255, 1'b1, 16'd12, 16'd90, 16'd15, 16'd35,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_WRIST, 16'd9, 8'd200, 1'b1, 16'd12, 16'd91, 16'd15, 16'd36,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_FINGER, 16'd10, 8'd90, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_WRIST, 16'd10, 8'd80, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_WRIST, 16'd10, 8'd255, 1'b0, 16'd12, 16'd4, 16'd15, 16'd8,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_FINGER, 16'd11, 8'd60, 1'b1, 16'hFFFF, 16'd50, 16'hFFFF, 16'd20,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		// reset of the fusion state and the unused command both give all zero
		'{CMD_RESET, 16'hFFFF, 8'd255, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1'b1, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_UNUSED, 16'hFFFF, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_FINGER, 16'hFFFF, 8'd255, 1'b1, 16'd12, 16'd4, 16'd15, 16'd8,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_WRIST, 16'hFFFF, 8'd1, 1'b1, 16'd12, 16'd4, 16'd15, 16'd8,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		// warm-up rate above the window is rejected
		'{CMD_FINGER, 16'd0, 8'd255, 1'b1, 16'd12, 16'd4, 16'd15, 16'd8,
			1'b1, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_FINGER, 16'd2, 8'd40, 1'b1, 16'd100, 16'd10, 16'd100, 16'd10,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0},
		'{CMD_WRIST, 16'd2, 8'd40, 1'b1, 16'd100, 16'd10, 16'd100, 16'd10,
			1'b0, 8'd0, 7'd0, 1'b0, 1'b0}
	};

	finger_wrist_heart_rate_fusion uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Waveform quality points in hundredths.
	function automatic int unsigned waveform_points(input item_t it);
		int unsigned pts;
		pts = 0;
		if (it.wave_valid) begin
			if ($signed(it.prominence) >= 12) pts += 35;
			if ($signed(it.spread) >= 4 && $signed(it.spread) <= 90) pts += 25;
			if ($signed(it.peak_energy) >= 15) pts += 20;
			if ($signed(it.dominant_freq) >= 8 && $signed(it.dominant_freq) <= 35) pts += 20;
		end
		return pts;
	endfunction

	function automatic logic in_active_band(input int unsigned r);
		return r >= ACT_LO && r <= ACT_HI;
	endfunction

	// Predict the result of one beat and advance the stored finger beat.
	function automatic result_t fuse_beat(input cmd_t c, input item_t it);
		result_t     res;
		int unsigned hr, fused, gap, pts;
		logic        warm, accept, paired, settled;
		res = '0;
		hr = 32'(it.rate_in);
		case (c)
			CMD_FINGER: begin
				warm = it.pulse_number >= warm_id_lo && it.pulse_number <= warm_id_hi;
				accept = 1'b0;
				if (hr == 0) begin
					if (warm) begin
						hr = 32'(WARM_DEF);
						accept = 1'b1;
					end
				end else if (warm) begin
					accept = hr >= warm_rate_lo && hr <= warm_rate_hi;
				end else if (hr >= FINGER_MIN) begin
					if (hr < OX_LO) hr = 32'(OX_LO);
					accept = 1'b1;
				end
				if (accept) begin
					res.rate_out = hr[7:0];
					res.quality = 7'(waveform_points(it));
					res.finger_good = 1'b1;
					stored_pulse = it.pulse_number;
					stored_rate = hr[7:0];
					if (in_active_band(hr)) begin
						stored_valid = 1'b1;
						stored_active = 1'b1;
						session_live = 1'b1;
					end else if (session_live) begin
						stored_valid = 1'b1;
						stored_active = 1'b1;
					end else begin
						stored_valid = hr >= OX_LO && hr <= OX_HI;
						stored_active = 1'b0;
					end
				end
			end
			CMD_WRIST: begin
				if (hr != 0) begin
					paired = stored_valid && stored_pulse == it.pulse_number;
					settled = 1'b0;
					pts = waveform_points(it);
					res.wrist_good = 1'b1;
					if (in_active_band(hr) || session_live || stored_active) begin
						if (paired) res.finger_good = 1'b1;
						if (paired && (stored_active || session_live) &&
								stored_rate > hr + GAP_MAX) begin
							fused = (stored_rate * 9 + hr + 5) / 10;
							if (fused < hr) fused = hr;
							if (fused > ACT_HI) fused = 32'(ACT_HI);
							pts += 15;
							res.rate_out = fused[7:0];
						end else begin
							res.rate_out = (hr > ACT_HI) ? ACT_HI : hr[7:0];
						end
						settled = 1'b1;
					end else if (paired && stored_rate >= OX_LO && stored_rate <= OX_HI) begin
						res.finger_good = 1'b1;
						gap = (hr > stored_rate) ? hr - stored_rate : stored_rate - hr;
						if (gap > GAP_MAX) begin
							fused = (hr * 2 + stored_rate * 3 + 2) / 5;
							if (fused < OX_LO) fused = 32'(OX_LO);
							if (fused > CALM_CAP) fused = 32'(CALM_CAP);
							pts += 15;
							res.rate_out = fused[7:0];
							settled = 1'b1;
						end
					end
					if (!settled) begin
						fused = (hr > CALM_CAP) ? (hr * 3 + 70) / 4 : hr;
						res.rate_out = fused[7:0];
					end
					res.quality = pts[6:0];
				end
			end
			CMD_RESET: begin
				stored_valid = 1'b0;
				stored_active = 1'b0;
				session_live = 1'b0;
			end
			default: ;
		endcase
		return res;
	endfunction

	// Offer one beat in the current burst; record its expectation once taken.
	task automatic feed_item(input cmd_t c, input item_t it, input logic typed,
			input result_t typed_res);
		result_t want;
		int      idle_len;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idle_len != 0 && hold_left == 0) begin
				s_tvalid <= 1'b0;
				repeat (idle_len) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= it;
		s_tuser <= c;
		do @(posedge clk); while (!s_tready);
		want = fuse_beat(c, it);
		if (typed) want = typed_res;
		pending_results.push_back(want);
		beats_taken++;
	endtask

	// Stop offering and wait until every result is back and the pipeline is empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the caller lowers cfg_valid after its last write.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WARMUP_ID_LOW:   warm_id_lo = value;
			REG_WARMUP_ID_HIGH:  warm_id_hi = value;
			REG_WARMUP_RATE_MIN: warm_rate_lo = value[7:0];
			REG_WARMUP_RATE_MAX: warm_rate_hi = value[7:0];
			default: ;
		endcase
	endtask

	// Warm-up settings per phase: defaults, extremes, empty windows, then random.
	task automatic set_config(input int phase);
		logic [15:0] lo, hi;
		logic [7:0]  rmin, rmax;
		case (phase)
			0: begin lo = 16'd0; hi = 16'd2; rmin = 8'd40; rmax = 8'd150; end
			1: begin lo = 16'd0; hi = 16'hFFFF; rmin = 8'd0; rmax = 8'd255; end
			2: begin lo = 16'd100; hi = 16'd50; rmin = 8'd40; rmax = 8'd150; end
			3: begin lo = 16'd10; hi = 16'd20; rmin = 8'd255; rmax = 8'd0; end
			4: begin lo = 16'hFFFF; hi = 16'hFFFF; rmin = 8'd255; rmax = 8'd255; end
			default: begin
				lo = 16'($urandom_range(0, 30));
				hi = lo + 16'($urandom_range(0, 10));
				rmin = 8'($urandom_range(30, 70));
				rmax = 8'($urandom_range(100, 200));
			end
		endcase
		write_reg(REG_WARMUP_ID_LOW, lo);
		write_reg(REG_WARMUP_ID_HIGH, hi);
		write_reg(REG_WARMUP_RATE_MIN, {8'd0, rmin});
		write_reg(REG_WARMUP_RATE_MAX, {8'd0, rmax});
		cfg_valid <= 1'b0;
	endtask

	// Feature value near the score thresholds, or any 16-bit value.
	function automatic logic [15:0] draw_feature();
		int v;
		if ($urandom_range(0, 1) == 0) return 16'($urandom);
		v = $urandom_range(0, 110);
		v = v - 10;
		return v[15:0];
	endfunction

	// Random beat: mostly finger/wrist pairs on the same pulse, some noise.
	task automatic random_item(output cmd_t c, output item_t it);
		int pick;
		it = '0;
		pick = $urandom_range(0, 99);
		if (pick < 45) c = CMD_FINGER;
		else if (pick < 90) c = CMD_WRIST;
		else if (pick < 95) c = CMD_RESET;
		else c = CMD_UNUSED;
		pick = $urandom_range(0, 99);
		if (c == CMD_WRIST && pick < 65) begin
			it.pulse_number = recent_finger;
		end else if (pick < 80) begin
			it.pulse_number = next_pulse;
		end else if (pick < 92) begin
			it.pulse_number = warm_id_lo + 16'($urandom_range(0, 12));
		end else begin
			it.pulse_number = 16'($urandom);
		end
		if (c == CMD_FINGER) begin
			recent_finger = it.pulse_number;
			next_pulse = next_pulse + 16'd1;
		end
		pick = $urandom_range(0, 99);
		if (pick < 10) it.rate_in = 8'd0;
		else if (pick < 25) it.rate_in = 8'($urandom_range(1, 255));
		else it.rate_in = 8'($urandom_range(50, 110));
		it.wave_valid = ($urandom_range(0, 4) != 0);
		it.prominence = draw_feature();
		it.spread = draw_feature();
		it.peak_energy = draw_feature();
		it.dominant_freq = draw_feature();
	endtask

	// Receiver: stall pattern switches among four modes, with one long hold-off
	// while the sender keeps offering.
	initial begin
		int unsigned cyc;
		int          mode;
		logic        pressure_done;
		cyc = 0;
		mode = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!pressure_done && beats_taken >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= (cyc[1:0] != 2'd3);
					2: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
			cyc++;
			if (cyc[5:0] == 6'd0) mode = $urandom_range(0, 3);
		end
	end

	// Result checker: every taken beat against the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation pending: %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.rate_out !== want.rate_out) begin
					$error("rate_out: expected %0d, got %0d", want.rate_out, got.rate_out);
					mismatches++;
				end
				if (got.quality !== want.quality) begin
					$error("quality: expected %0d, got %0d", want.quality, got.quality);
					mismatches++;
				end
				if (got.finger_good !== want.finger_good) begin
					$error("finger_good: expected %0d, got %0d", want.finger_good,
						got.finger_good);
					mismatches++;
				end
				if (got.wrist_good !== want.wrist_good) begin
					$error("wrist_good: expected %0d, got %0d", want.wrist_good,
						got.wrist_good);
					mismatches++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random phases under new settings.
	initial begin
		item_t   it;
		result_t typed_res;
		cmd_t    c;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBES; i++) begin
			it = '0;
			it.pulse_number = probes[i].pulse;
			it.rate_in = probes[i].rate;
			it.wave_valid = probes[i].wave_ok;
			it.prominence = probes[i].prom;
			it.spread = probes[i].spread;
			it.peak_energy = probes[i].energy;
			it.dominant_freq = probes[i].freq;
			typed_res = '0;
			typed_res.rate_out = probes[i].x_rate;
			typed_res.quality = probes[i].x_quality;
			typed_res.finger_good = probes[i].x_finger;
			typed_res.wrist_good = probes[i].x_wrist;
			feed_item(probes[i].cmd, it, probes[i].typed, typed_res);
		end
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			set_config(phase);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_item(c, it);
				feed_item(c, it, 1'b0, '0);
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("finger_wrist_heart_rate_fusion regression: pass");
		end else begin
			$display("finger_wrist_heart_rate_fusion regression: fail");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("finger_wrist_heart_rate_fusion regression: fail");
		$finish;
	end

endmodule
